>>> rtl/tmsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tmsp_pkg;
    typedef enum logic [1:0] {
        PH_ACCEL  = 2'd0,
        PH_CRUISE = 2'd1,
        PH_DECEL  = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    localparam int unsigned CFG_PEAK_VELOCITY = 0;
    localparam int unsigned CFG_ACCEL_RATE    = 1;
endpackage
`default_nettype wire

>>> rtl/tmsp_divu.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage, with a stall enable.
// Bits of num above QW seed the remainder, so the quotient must fit in QW bits.
module tmsp_divu #(
    parameter int NW = 64,
    parameter int DW = 32,
    parameter int QW = 48
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic      [QW-1:0] quo
);
    logic [NW-1:0] n_reg [0:QW];
    logic [DW:0]   r_reg [0:QW];
    logic [DW-1:0] d_reg [0:QW];
    logic [QW-1:0] q_reg [0:QW];

    always_comb
    begin
        n_reg[0] = num << (NW - QW);
        r_reg[0] = (DW+1)'(num >> QW);
        d_reg[0] = den;
        q_reg[0] = '0;
    end

    genvar i;
    generate
        for (i = 0; i < QW; i++)
        begin : g_st
            logic [DW+1:0] trial;
            assign trial = {r_reg[i], n_reg[i][NW-1]} - {2'b00, d_reg[i]};
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_reg[i+1] <= n_reg[i] << 1;
                    d_reg[i+1] <= d_reg[i];
                    if (!trial[DW+1])
                    begin
                        r_reg[i+1] <= trial[DW:0];
                        q_reg[i+1] <= {q_reg[i][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        r_reg[i+1] <= {r_reg[i][DW-1:0], n_reg[i][NW-1]};
                        q_reg[i+1] <= {q_reg[i][QW-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign quo = q_reg[QW];
endmodule
`default_nettype wire

>>> rtl/tmsp_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipelined integer square root of a 64-bit value, one result bit per stage.
module tmsp_sqrt (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [63:0] rad,
    output logic      [31:0] root
);
    logic [63:0] n_reg [0:32];
    logic [33:0] r_reg [0:32];
    logic [31:0] q_reg [0:32];

    always_comb
    begin
        n_reg[0] = rad;
        r_reg[0] = '0;
        q_reg[0] = '0;
    end

    genvar i;
    generate
        for (i = 0; i < 32; i++)
        begin : g_st
            logic [35:0] rem2;
            logic [35:0] trial;
            assign rem2  = {r_reg[i], n_reg[i][63:62]};
            assign trial = rem2 - {2'b00, q_reg[i], 2'b01};
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_reg[i+1] <= n_reg[i] << 2;
                    if (!trial[35])
                    begin
                        r_reg[i+1] <= trial[33:0];
                        q_reg[i+1] <= {q_reg[i][30:0], 1'b1};
                    end
                    else
                    begin
                        r_reg[i+1] <= rem2[33:0];
                        q_reg[i+1] <= {q_reg[i][30:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign root = q_reg[32];
endmodule
`default_nettype wire

>>> rtl/trapezoid_motion_setpoint.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: sqrt, ta divide and cruise divide chains, then the product and selection
//   registers, between request accepted and result valid.
// Throughput: one request per cycle; the whole pipe stalls when the output
//   register is full and not taken.
// Reset: rst_n clears valid bits and sets both rate registers to 1.0 (65536).
module trapezoid_motion_setpoint
    import tmsp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [31:0] start_angle, [63:32] goal_angle, [95:64] elapsed_time
    input  wire logic [95:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [31:0] setpoint_angle, [33:32] phase, [39:34] zero
    output logic      [39:0] m_tdata,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam int F   = FRAC_BITS;
    localparam int QW  = 32 + F;
    localparam int NS  = 32;
    localparam int ND1 = QW;
    localparam int NW2 = 33 + F;
    localparam int ND2 = QW;
    localparam int LAT = NS + ND1 + ND2 + 9;

    logic [31:0] vel_reg;
    logic [31:0] acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_reg <= 32'd65536;
            acc_reg <= 32'd65536;
        end
        else if (cfg_we)
        begin
            if (cfg_index == 1'(CFG_PEAK_VELOCITY))
                vel_reg <= cfg_data;
            else
                acc_reg <= cfg_data;
        end
    end

    logic [31:0] v, a;
    assign v = (vel_reg == '0) ? 32'd1 : vel_reg;
    assign a = (acc_reg == '0) ? 32'd1 : acc_reg;

    logic en;
    assign en = !m_tvalid || m_tready;
    assign s_tready = en;

    // valid and per-item context shift lines
    logic        vld_reg [0:LAT];
    logic [31:0] st_reg  [0:LAT];
    logic [31:0] gl_reg  [0:LAT];
    logic [31:0] t_reg   [0:LAT];
    logic [31:0] d_reg   [0:LAT];
    logic        up_reg  [0:LAT];

    // stage 0: distance
    logic signed [32:0] diff;
    assign diff = {s_tdata[63], s_tdata[63:32]} - {s_tdata[31], s_tdata[31:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int k = 0; k <= LAT; k++)
                vld_reg[k] <= 1'b0;
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int k = 1; k <= LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= s_tdata[31:0];
            gl_reg[0] <= s_tdata[63:32];
            t_reg[0]  <= s_tdata[95:64];
            up_reg[0] <= !diff[32] && (diff != '0);
            d_reg[0]  <= diff[32] ? 32'(-diff) : diff[31:0];
            for (int k = 1; k <= LAT; k++)
            begin
                st_reg[k] <= st_reg[k-1];
                gl_reg[k] <= gl_reg[k-1];
                t_reg[k]  <= t_reg[k-1];
                d_reg[k]  <= d_reg[k-1];
                up_reg[k] <= up_reg[k-1];
            end
        end
    end

    // stage 1: products
    logic [63:0] da_reg, vv_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            da_reg <= 64'(d_reg[0]) * 64'(a);
            vv_reg <= 64'(v) * 64'(v);
        end
    end

    // stage 2: choose shape; sqrt line starts
    logic trap_line [2:LAT];
    logic [63:0] vv_line [2:NS+3];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            trap_line[2] <= da_reg > vv_reg;
            vv_line[2]   <= vv_reg;
            for (int k = 3; k <= LAT; k++)
                trap_line[k] <= trap_line[k-1];
            for (int k = 3; k <= NS + 3; k++)
                vv_line[k] <= vv_line[k-1];
        end
    end

    logic [31:0] vp;
    tmsp_sqrt u_sqrt (
        .clk (clk),
        .en  (en),
        .rad (da_reg),
        .root(vp)
    );
    // sqrt output aligned with index NS+1; vp_reg brings it to NS+2
    localparam int P1 = NS + 2;
    logic [31:0] vp_reg;
    logic [31:0] pk_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vp_reg <= vp;
            pk_reg <= trap_line[P1] ? v : vp_reg;
        end
    end

    // ta = pk*2^F / a ; pa = vv / 2a computed in parallel
    logic [QW-1:0] ta_q;
    tmsp_divu #(.NW(64), .DW(32), .QW(QW)) u_div_ta (
        .clk(clk), .en(en),
        .num(64'(pk_reg) << F), .den(a), .quo(ta_q)
    );
    logic [31:0] pa_q;
    tmsp_divu #(.NW(64), .DW(32), .QW(32)) u_div_pa (
        .clk(clk), .en(en),
        .num(vv_line[P1 + 1] >> 1), .den(a), .quo(pa_q)
    );
    // pa divider has 32 stages against ND1 for ta; pa_dl delays its quotient to match
    localparam int PA_D = ND1 - 32;
    logic [31:0] pa_dl [0:PA_D];
    always_comb pa_dl[0] = pa_q;
    genvar g;
    generate
        for (g = 1; g <= PA_D; g++)
        begin : g_pad
            always_ff @(posedge clk)
                if (en) pa_dl[g] <= pa_dl[g-1];
        end
    endgenerate

    localparam int P2 = P1 + 1 + ND1;
    logic [QW-1:0] ta_reg;
    logic [31:0]   pa_reg;
    logic [NW2-1:0] cn_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ta_reg <= ta_q;
            pa_reg <= trap_line[P2] ? pa_dl[PA_D] : 32'd0;
            cn_reg <= NW2'(d_reg[P2] - {pa_dl[PA_D][30:0], 1'b0}) << F;
        end
    end

    logic [QW-1:0] tc_q;
    tmsp_divu #(.NW(NW2), .DW(32), .QW(QW)) u_div_tc (
        .clk(clk), .en(en), .num(cn_reg), .den(v), .quo(tc_q)
    );
    logic [QW-1:0] ta_dl [0:ND2];
    logic [31:0]   pa_l  [0:ND2];
    always_comb
    begin
        ta_dl[0] = ta_reg;
        pa_l[0]  = pa_reg;
    end
    generate
        for (g = 1; g <= ND2; g++)
        begin : g_tad
            always_ff @(posedge clk)
                if (en)
                begin
                    ta_dl[g] <= ta_dl[g-1];
                    pa_l[g]  <= pa_l[g-1];
                end
        end
    endgenerate

    // phase decision
    localparam int P3 = P2 + 1 + ND2;
    logic [QW+1:0] ta3_reg, tc3_reg, tt3_reg;
    logic [31:0]   pa3_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ta3_reg <= (QW+2)'(ta_dl[ND2]);
            tc3_reg <= trap_line[P3] ? (QW+2)'(tc_q) : '0;
            tt3_reg <= ((QW+2)'(ta_dl[ND2]) << 1)
                       + (trap_line[P3] ? (QW+2)'(tc_q) : '0);
            pa3_reg <= pa_l[ND2];
        end
    end

    logic [1:0]    ph4_reg;
    logic [QW+1:0] tq;
    assign tq  = (QW+2)'(t_reg[P3+1]);
    logic [31:0] mop_reg;
    logic [31:0] pa4_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa4_reg <= pa3_reg;
            if (tq <= ta3_reg)
            begin
                ph4_reg <= PH_ACCEL;
                mop_reg <= t_reg[P3+1];
            end
            else if (tq <= ta3_reg + tc3_reg)
            begin
                ph4_reg <= PH_CRUISE;
                mop_reg <= 32'(tq - ta3_reg);
            end
            else if (tq <= tt3_reg)
            begin
                ph4_reg <= PH_DECEL;
                mop_reg <= 32'(tt3_reg - tq);
            end
            else
            begin
                ph4_reg <= PH_DONE;
                mop_reg <= '0;
            end
        end
    end

    // products; the ramp term a*m*m takes two 32x32 halves and a sum
    logic [1:0]  ph5_reg, ph6_reg, ph7_reg;
    logic [63:0] p5_reg, lo6_reg, hi6_reg;
    logic [31:0] m5_reg, pa5_reg, pa6_reg, pa7_reg;
    logic [95:0] p7_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph5_reg <= ph4_reg;
            pa5_reg <= pa4_reg;
            m5_reg  <= mop_reg;
            p5_reg  <= (ph4_reg == PH_CRUISE) ? 64'(v) * 64'(mop_reg)
                                              : 64'(a) * 64'(mop_reg);
            ph6_reg <= ph5_reg;
            pa6_reg <= pa5_reg;
            if (ph5_reg == PH_CRUISE)
            begin
                lo6_reg <= p5_reg;
                hi6_reg <= '0;
            end
            else
            begin
                lo6_reg <= 64'(p5_reg[31:0]) * 64'(m5_reg);
                hi6_reg <= 64'(p5_reg[63:32]) * 64'(m5_reg);
            end
            ph7_reg <= ph6_reg;
            pa7_reg <= pa6_reg;
            p7_reg  <= {hi6_reg, 32'd0} + 96'(lo6_reg);
        end
    end

    localparam int PF = P3 + 5;
    logic [31:0] trv;
    always_comb
    begin
        case (ph7_reg)
            PH_ACCEL:  trv = 32'(p7_reg >> (2 * F + 1));
            PH_CRUISE: trv = pa7_reg + 32'(p7_reg >> F);
            PH_DECEL:  trv = d_reg[PF] - 32'(p7_reg >> (2 * F + 1));
            default:   trv = d_reg[PF];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid <= 1'b0;
        else if (en)
            m_tvalid <= vld_reg[PF];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata[39:32] <= {6'd0, ph7_reg};
            if (ph7_reg == PH_DONE)
                m_tdata[31:0] <= gl_reg[PF];
            else if (up_reg[PF])
                m_tdata[31:0] <= st_reg[PF] + trv;
            else
                m_tdata[31:0] <= st_reg[PF] - trv;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result lost under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready mismatch");
    assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[PF] |=> m_tvalid)
        else $error("pipeline dropped item");
endmodule
`default_nettype wire
